/* sv/ptex_pkg.sv */
package ptex_pkg;

   // Operation codes carried by req_op.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Register indexes on the csr write channel.
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_END_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_END_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FLIP     = 3'd7;

   localparam int unsigned COORD_W = 32;             // Q16.16 coordinate
   localparam int unsigned DIFF_W  = COORD_W + 1;    // difference of two coordinates
   localparam int unsigned DIM_W   = 11;             // width, height, stride
   localparam int unsigned PROD_W  = DIFF_W + DIM_W; // dividend width
   localparam int unsigned TEXEL_W = 8;
   localparam int unsigned QUO_W   = DIM_W;          // quotient stays below 2**DIM_W

   // One axis in flight through the restoring divider.
   typedef struct packed {
      logic              ok;   // in range so far
      logic              neg;  // quotient is negated (signs differ, nonzero numerator)
      logic [PROD_W-1:0] rem;
      logic [DIFF_W-1:0] den;
      logic [QUO_W-1:0]  quo;
   } div_type;

   // One restoring step for quotient bit SH.
   function automatic div_type div_step(input div_type d, input int unsigned sh);
      logic [PROD_W-1:0] shifted;
      div_type           r;
      shifted = {{DIM_W{1'b0}}, d.den} << sh;
      r = d;
      if (d.rem >= shifted) begin
         r.rem     = d.rem - shifted;
         r.quo[sh] = 1'b1;
      end
      return r;
   endfunction

endpackage

/* sv/ptex_ram.sv */
module ptex_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/planar_texture_texel_fetch.sv */
// Nearest-texel lookup into an 8-bit grayscale image held in on-chip memory.
//
// Items are issued on the command channel: an item is taken at a rising edge
// where start is high and busy is low. busy is always low, so one item can be
// taken in every cycle. With req_op low the item writes req_load_data into the
// texel word req_load_addr; with req_op high it looks up the point
// (req_pos_x, req_pos_y), given in signed Q16.16.
//
// Every item produces exactly one result beat, in issue order. The item moves
// through stages 1 to 3, the divider stages, stages 15 and 16 and the result
// register, which drives the beat with rsp_valid high.
// Writes answer with rsp_hit low and rsp_gray zero. A lookup that falls
// outside the image, or a zero-span rectangle, also answers with a miss. The
// receiver cannot stall the block, and the pipeline never stalls on its own.
//
// The 11-stage restoring divider, one quotient bit per stage, scales each
// coordinate, and the memory's read port is registered. The csr channel is
// always ready; registers must be written only while no item is in flight,
// which the block itself does not enforce. Reset clears the pipeline valid
// bits and loads the register defaults; the texel memory is not cleared and holds garbage until written.
module planar_texture_texel_fetch
   import ptex_pkg::*;
#(
   parameter int unsigned IMAGE_WORDS = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   // command channel
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_op,
   input  logic [COORD_W-1:0]   req_pos_x,
   input  logic [COORD_W-1:0]   req_pos_y,
   input  logic [15:0]          req_load_addr,
   input  logic [TEXEL_W-1:0]   req_load_data,
   // result channel
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output logic [TEXEL_W-1:0]   rsp_gray,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

   // The memory size must be a power of two; addresses wrap modulo its size.
   localparam int unsigned AW  = $clog2(IMAGE_WORDS);
   localparam int unsigned LAT = 17;

   typedef struct packed {
      logic               valid;
      logic               op;
      logic [AW-1:0]      laddr;
      logic [TEXEL_W-1:0] ldata;
   } item_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [COORD_W-1:0] origin_x_ff, origin_y_ff, end_x_ff, end_y_ff;
   logic [DIM_W-1:0]   width_ff, height_ff, stride_ff;
   logic               flip_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         end_x_ff    <= COORD_W'(65536);
         end_y_ff    <= COORD_W'(65536);
         width_ff    <= DIM_W'(1);
         height_ff   <= DIM_W'(1);
         stride_ff   <= DIM_W'(1);
         flip_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ORIGIN_X: origin_x_ff <= csr_wdata;
            REG_ORIGIN_Y: origin_y_ff <= csr_wdata;
            REG_END_X:    end_x_ff    <= csr_wdata;
            REG_END_Y:    end_y_ff    <= csr_wdata;
            REG_WIDTH:    width_ff    <= csr_wdata[DIM_W-1:0];
            REG_HEIGHT:   height_ff   <= csr_wdata[DIM_W-1:0];
            REG_STRIDE:   stride_ff   <= csr_wdata[DIM_W-1:0];
            REG_FLIP:     flip_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: take the item and form the signed differences.
   // ------------------------------------------------------------------
   item_type          s1_ff, s1_in;
   logic [DIFF_W-1:0] dx1_ff, bx1_ff, dy1_ff, by1_ff;

   always_comb begin
      s1_in.valid = start && !busy;
      s1_in.op    = req_op;
      s1_in.laddr = AW'(req_load_addr);
      s1_in.ldata = req_load_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= s1_in.valid;
      end
      s1_ff.op    <= s1_in.op;
      s1_ff.laddr <= s1_in.laddr;
      s1_ff.ldata <= s1_in.ldata;
      dx1_ff <= {req_pos_x[COORD_W-1], req_pos_x} - {origin_x_ff[COORD_W-1], origin_x_ff};
      bx1_ff <= {end_x_ff[COORD_W-1], end_x_ff} - {origin_x_ff[COORD_W-1], origin_x_ff};
      dy1_ff <= {req_pos_y[COORD_W-1], req_pos_y} - {origin_y_ff[COORD_W-1], origin_y_ff};
      by1_ff <= {end_y_ff[COORD_W-1], end_y_ff} - {origin_y_ff[COORD_W-1], origin_y_ff};
   end

   // ------------------------------------------------------------------
   // Stage 2: magnitudes and range test. The index lands in [0, n) only when
   // |num| < |den|; with opposite signs it must also truncate to zero.
   // ------------------------------------------------------------------
   item_type          s2_ff;
   logic [DIFF_W-1:0] ax2_ff, adx2_ff, ay2_ff, ady2_ff;
   logic              okx2_ff, negx2_ff, oky2_ff, negy2_ff;
   logic [DIFF_W-1:0] ax_in, adx_in, ay_in, ady_in;

   always_comb begin
      ax_in  = dx1_ff[DIFF_W-1] ? DIFF_W'(-dx1_ff) : dx1_ff;
      adx_in = bx1_ff[DIFF_W-1] ? DIFF_W'(-bx1_ff) : bx1_ff;
      ay_in  = dy1_ff[DIFF_W-1] ? DIFF_W'(-dy1_ff) : dy1_ff;
      ady_in = by1_ff[DIFF_W-1] ? DIFF_W'(-by1_ff) : by1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else begin
         s2_ff.valid <= s1_ff.valid;
      end
      s2_ff.op    <= s1_ff.op;
      s2_ff.laddr <= s1_ff.laddr;
      s2_ff.ldata <= s1_ff.ldata;
      ax2_ff   <= ax_in;
      adx2_ff  <= adx_in;
      ay2_ff   <= ay_in;
      ady2_ff  <= ady_in;
      okx2_ff  <= (bx1_ff != '0) && (width_ff != '0) && (ax_in < adx_in);
      oky2_ff  <= (by1_ff != '0) && (height_ff != '0) && (ay_in < ady_in);
      negx2_ff <= (dx1_ff[DIFF_W-1] != bx1_ff[DIFF_W-1]) && (dx1_ff != '0);
      negy2_ff <= (dy1_ff[DIFF_W-1] != by1_ff[DIFF_W-1]) && (dy1_ff != '0);
   end

   // ------------------------------------------------------------------
   // Stage 3: scale the numerators by the image dimensions.
   // ------------------------------------------------------------------
   item_type s3_ff;
   div_type  dx3_ff, dy3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else begin
         s3_ff.valid <= s2_ff.valid;
      end
      s3_ff.op    <= s2_ff.op;
      s3_ff.laddr <= s2_ff.laddr;
      s3_ff.ldata <= s2_ff.ldata;
      dx3_ff.ok  <= okx2_ff;
      dx3_ff.neg <= negx2_ff;
      dx3_ff.rem <= PROD_W'(ax2_ff) * PROD_W'(width_ff);
      dx3_ff.den <= adx2_ff;
      dx3_ff.quo <= '0;
      dy3_ff.ok  <= oky2_ff;
      dy3_ff.neg <= negy2_ff;
      dy3_ff.rem <= PROD_W'(ay2_ff) * PROD_W'(height_ff);
      dy3_ff.den <= ady2_ff;
      dy3_ff.quo <= '0;
   end

   // ------------------------------------------------------------------
   // Stages 4 to 14: restoring division, most significant quotient bit first.
   // ------------------------------------------------------------------
   item_type dv_it_ff [QUO_W];
   div_type  dvx_ff   [QUO_W];
   div_type  dvy_ff   [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      item_type it_prev;
      div_type  x_prev, y_prev;

      if (k == 0) begin : g_first
         assign it_prev = s3_ff;
         assign x_prev  = dx3_ff;
         assign y_prev  = dy3_ff;
      end else begin : g_next
         assign it_prev = dv_it_ff[k-1];
         assign x_prev  = dvx_ff[k-1];
         assign y_prev  = dvy_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_it_ff[k].valid <= 1'b0;
         end else begin
            dv_it_ff[k].valid <= it_prev.valid;
         end
         dv_it_ff[k].op    <= it_prev.op;
         dv_it_ff[k].laddr <= it_prev.laddr;
         dv_it_ff[k].ldata <= it_prev.ldata;
         dvx_ff[k] <= div_step(x_prev, QUO_W - 1 - k);
         dvy_ff[k] <= div_step(y_prev, QUO_W - 1 - k);
      end
   end

   // ------------------------------------------------------------------
   // Stage 15: hit decision, optional row mirror, row times stride.
   // ------------------------------------------------------------------
   item_type              s15_ff;
   logic                  hit15_ff;
   logic [DIM_W-1:0]      col15_ff;
   logic [2*DIM_W-1:0]    prod15_ff;
   div_type               qx, qy;
   logic                  hit_in;
   logic [DIM_W-1:0]      row_in;

   always_comb begin
      qx     = dvx_ff[QUO_W-1];
      qy     = dvy_ff[QUO_W-1];
      hit_in = dv_it_ff[QUO_W-1].op == OP_LOOKUP
            && qx.ok && (!qx.neg || qx.quo == '0)
            && qy.ok && (!qy.neg || qy.quo == '0);
      row_in = flip_ff ? DIM_W'(height_ff - DIM_W'(1) - qy.quo) : qy.quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s15_ff.valid <= 1'b0;
      end else begin
         s15_ff.valid <= dv_it_ff[QUO_W-1].valid;
      end
      s15_ff.op    <= dv_it_ff[QUO_W-1].op;
      s15_ff.laddr <= dv_it_ff[QUO_W-1].laddr;
      s15_ff.ldata <= dv_it_ff[QUO_W-1].ldata;
      hit15_ff     <= hit_in;
      col15_ff     <= qx.quo;
      prod15_ff    <= (2*DIM_W)'(row_in) * (2*DIM_W)'(stride_ff);
   end

   // ------------------------------------------------------------------
   // Stage 16: final word address; writes and reads meet the memory here in
   // issue order, so a lookup always sees exactly the writes issued before it.
   // ------------------------------------------------------------------
   item_type            s16_ff;
   logic                hit16_ff;
   logic [AW-1:0]       addr16_ff;
   logic [2*DIM_W:0]    addr_sum;

   assign addr_sum = {1'b0, prod15_ff} + (2*DIM_W+1)'(col15_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s16_ff.valid <= 1'b0;
      end else begin
         s16_ff.valid <= s15_ff.valid;
      end
      s16_ff.op    <= s15_ff.op;
      s16_ff.laddr <= s15_ff.laddr;
      s16_ff.ldata <= s15_ff.ldata;
      hit16_ff     <= hit15_ff;
      addr16_ff    <= addr_sum[AW-1:0];
   end

   logic [TEXEL_W-1:0] rd_data;

   ptex_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (IMAGE_WORDS)
   ) u_texel_ram (
      .clock   (clock),
      .wr_en   (s16_ff.valid && s16_ff.op == OP_WRITE),
      .wr_addr (s16_ff.laddr),
      .wr_data (s16_ff.ldata),
      .rd_en   (s16_ff.valid && hit16_ff),
      .rd_addr (addr16_ff),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------------
   // Stage 17: result beat.
   // ------------------------------------------------------------------
   logic out_valid_ff, out_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s16_ff.valid;
      end
      out_hit_ff <= hit16_ff;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_hit   = out_valid_ff && out_hit_ff;
   assign rsp_gray  = (out_valid_ff && out_hit_ff) ? rd_data : '0;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // Every taken item comes out as one beat after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result beat missing after fixed latency");

   // A write item never reports a hit.
   a_write_miss: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_WRITE) |-> ##LAT (rsp_valid && !rsp_hit))
      else $error("write item reported a hit");

   // The divider leaves a remainder below the divisor on every in-range axis; the check covers the x axis.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (dv_it_ff[QUO_W-1].valid && qx.ok) |-> (qx.rem < PROD_W'(qx.den)))
      else $error("divider remainder not reduced");

   // A beat appears only for an item that was taken earlier.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(s16_ff.valid))
      else $error("result beat without an item");

endmodule
